// ----- sv/mtp_pkg.sv -----
// Shared constants for the move-to-position velocity profile core.
// Register map codes, reset values and datapath widths; no dependencies.
package mtp_pkg;

    // Default number of motor channels served.
    localparam int MTP_CHANNELS = 4;

    // Square-root unit widths: a 32-bit radicand gives a 16-bit root.
    localparam int MTP_RAD_W  = 32;
    localparam int MTP_ROOT_W = 16;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_DONE_THR  = 3'd0;
    localparam logic [2:0] REG_MIN_VEL   = 3'd1;
    localparam logic [2:0] REG_ACC_STEP  = 3'd2;
    localparam logic [2:0] REG_DEC_FACT  = 3'd3;
    localparam logic [2:0] REG_DEF_SPEED = 3'd4;

    // Register reset values.
    localparam logic [15:0] RST_DONE_THR  = 16'd40;
    localparam logic [15:0] RST_MIN_VEL   = 16'd15;
    localparam logic [15:0] RST_ACC_STEP  = 16'd150;
    localparam logic [7:0]  RST_DEC_FACT  = 8'd10;
    localparam logic [15:0] RST_DEF_SPEED = 16'd300;

endpackage

// ----- sv/move_to_position_velocity_profile_core.sv -----
// Top level of the move-to-position velocity profile core: sequencer, channel state and APB.
// Depends on mtp_pkg and the iterative square-root unit mtp_isqrt.
//
// Each input beat carries one control tick for one channel and yields exactly one output
// beat. The core takes one tick at a time. A tick that needs the deceleration curve
// occupies the core from one acceptance to the next through the 16-step square-root unit
// (two radicand bits per cycle), the start and completion of the root, and the sequencer
// steps around it. A tick that ends in a brake, or names a channel that is not fitted,
// skips the curve steps. A finished result waits in the output register, so the next tick
// is taken while it is still unclaimed. That tick is then held in its final step, and the
// input stays stalled, until the earlier result has been taken. Configuration must be written
// over the APB port only while no tick is in flight; the core itself does not enforce this.
module move_to_position_velocity_profile_core
    import mtp_pkg::*;
#(
    parameter int CHANNELS = MTP_CHANNELS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Tick input beat
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [1:0] channel, [33:2] goal_position, [65:34] current_position,
    // [97:66] speed_limit, [98] mode_entered, [103:99] zero
    input  logic [103:0] i_s_tdata,
    // Result output beat
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [16:0] velocity_setpoint, [17] brake, [18] done_res, [19] clear_integral,
    // [20] reset_controller, [23:21] zero
    output logic [23:0]  o_m_tdata,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_MAG, S_MUL, S_ROOT, S_LIM, S_DES, S_FIN
    } t_state;

    // Configuration registers
    logic [15:0] r_thr;
    logic [15:0] r_minv;
    logic [15:0] r_step;
    logic [7:0]  r_dec;
    logic [15:0] r_defsp;

    // Per-channel state
    logic [31:0]        r_last_goal [CHANNELS];
    logic signed [17:0] r_prof_vel  [CHANNELS];
    logic               r_done_flag [CHANNELS];

    // Sequencer and tick registers
    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_ch;
    logic [31:0]        r_goal;
    logic [31:0]        r_cur;
    logic [31:0]        r_lim;
    logic               r_entered;
    logic               r_in_range;
    logic               r_rst;
    logic               r_done_eff;
    logic signed [17:0] r_pv;
    logic [17:0]        r_apv;
    logic [31:0]        r_err;
    logic [31:0]        r_mag;
    logic [31:0]        r_limit;
    logic               r_dead;
    logic [15:0]        r_dmag;
    logic signed [17:0] r_desired;
    logic signed [18:0] r_diff;
    logic               r_up;
    logic               r_o_valid;
    logic [23:0]        r_o_data;

    logic [CH_W-1:0]    w_idx;
    logic               w_accept;
    logic               w_out_free;
    logic               w_rst;
    logic               w_done_eff;
    logic signed [17:0] w_pv_eff;
    logic [31:0]        w_mag;
    logic [39:0]        w_mul;
    logic [31:0]        w_radicand;
    logic               w_sqrt_start;
    logic               w_sqrt_done;
    logic [15:0]        w_root;
    logic [15:0]        w_root_m;
    logic [15:0]        w_dmag;
    logic signed [17:0] w_desired;
    logic signed [18:0] w_step;
    logic signed [18:0] w_diff_c;
    logic signed [18:0] w_pv_sum;
    logic signed [17:0] w_pv_new;
    logic               w_stop;
    logic               w_clr;

    // Signs a velocity magnitude by the direction of travel.
    function automatic logic signed [17:0] r_neg_sel(input logic neg, input logic [15:0] m);
        logic signed [17:0] v;
        v = $signed({2'b00, m});
        return neg ? -v : v;
    endfunction

    // APB: always ready, writes on the access cycle
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_DONE_THR;
            r_minv  <= RST_MIN_VEL;
            r_step  <= RST_ACC_STEP;
            r_dec   <= RST_DEC_FACT;
            r_defsp <= RST_DEF_SPEED;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_DONE_THR:  r_thr   <= pwdata[15:0];
                REG_MIN_VEL:   r_minv  <= pwdata[15:0];
                REG_ACC_STEP:  r_step  <= pwdata[15:0];
                REG_DEC_FACT:  r_dec   <= pwdata[7:0];
                REG_DEF_SPEED: r_defsp <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DONE_THR:  prdata = {16'd0, r_thr};
            REG_MIN_VEL:   prdata = {16'd0, r_minv};
            REG_ACC_STEP:  prdata = {16'd0, r_step};
            REG_DEC_FACT:  prdata = {24'd0, r_dec};
            REG_DEF_SPEED: prdata = {16'd0, r_defsp};
            default:       prdata = 32'd0;
        endcase
    end

    // Handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // Channel lookup and the clearing caused by mode entry or a new goal
    assign w_idx      = CH_W'(r_ch);
    assign w_rst      = r_entered || (r_goal != r_last_goal[w_idx]);
    assign w_done_eff = w_rst ? 1'b0 : r_done_flag[w_idx];
    assign w_pv_eff   = w_rst ? 18'sd0 : r_prof_vel[w_idx];

    // Error magnitude as an unsigned 32-bit value
    assign w_mag = r_err[31] ? (32'd0 - r_err) : r_err;

    // Curve radicand: 2 * factor * magnitude, wrapped to 32 bits
    assign w_mul        = r_mag * r_dec;
    assign w_radicand   = {w_mul[30:0], 1'b0};
    assign w_sqrt_start = (r_state == S_MUL);

    mtp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_radicand),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    // Raise to the crawl speed, then apply the limit
    assign w_root_m = (w_root < r_minv) ? r_minv : w_root;
    assign w_dmag   = ({16'd0, w_root_m} < r_limit) ? w_root_m : r_limit[15:0];

    assign w_desired = r_neg_sel(r_err[31], r_dmag);

    // Rate-limited speed-up
    assign w_step   = $signed({3'b000, r_step});
    assign w_diff_c = (r_diff > w_step) ? w_step : ((r_diff < -w_step) ? -w_step : r_diff);
    assign w_pv_sum = $signed({r_pv[17], r_pv}) + w_diff_c;

    // Final outcome of the tick
    assign w_stop   = r_done_eff || r_dead;
    assign w_clr    = !w_stop && !r_up;
    assign w_pv_new = r_done_eff ? r_pv :
                      r_dead     ? 18'sd0 :
                      r_up       ? w_pv_sum[17:0] : r_desired;

    // Next-state logic of the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_PREP;
            S_PREP: n_state = S_MAG;
            S_MAG: begin
                if (!r_in_range || r_done_eff || (w_mag <= {16'd0, r_thr})) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ROOT;
            S_ROOT: if (w_sqrt_done) n_state = S_LIM;
            S_LIM:  n_state = S_DES;
            S_DES:  n_state = S_FIN;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer, datapath registers, channel state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_goal[i] <= 32'd0;
                r_prof_vel[i]  <= 18'sd0;
                r_done_flag[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            // A taken beat empties the output register unless a new one replaces it.
            if (r_o_valid && i_m_tready && (r_state != S_FIN)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ch      <= i_s_tdata[1:0];
                        r_goal    <= i_s_tdata[33:2];
                        r_cur     <= i_s_tdata[65:34];
                        r_lim     <= i_s_tdata[97:66];
                        r_entered <= i_s_tdata[98];
                    end
                end
                S_PREP: begin
                    r_in_range <= ({30'd0, r_ch} < 32'(CHANNELS));
                    r_rst      <= w_rst;
                    r_done_eff <= w_done_eff;
                    r_pv       <= w_pv_eff;
                    r_apv      <= (w_pv_eff < 0) ? 18'(-w_pv_eff) : 18'(w_pv_eff);
                    r_err      <= r_goal - r_cur;
                end
                S_MAG: begin
                    r_mag   <= w_mag;
                    r_dead  <= (w_mag <= {16'd0, r_thr});
                    r_limit <= ((r_lim == 32'd0) || r_lim[31]) ? {16'd0, r_defsp} : r_lim;
                end
                S_LIM: begin
                    r_dmag <= w_dmag;
                end
                S_DES: begin
                    r_desired <= w_desired;
                    r_diff    <= $signed({w_desired[17], w_desired}) - $signed({r_pv[17], r_pv});
                    r_up      <= ({2'b00, r_dmag} >= r_apv);
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        if (r_in_range) begin
                            r_last_goal[w_idx] <= r_goal;
                            r_prof_vel[w_idx]  <= w_pv_new;
                            r_done_flag[w_idx] <= w_stop;
                            r_o_data <= {3'b000, r_rst, w_clr, w_stop, w_stop,
                                         w_stop ? 17'd0 : w_pv_new[16:0]};
                        end else begin
                            r_o_data <= 24'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The root unit only reports back while the sequencer waits for it.
    a_root_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> r_state == S_ROOT)
        else $error("square root finished outside its wait state");

    // A braking result never carries velocity or an integral clear.
    a_brake_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17] |-> o_m_tdata[16:0] == 17'd0 && !o_m_tdata[19])
        else $error("braking result with velocity or integral clear");

    // Done and brake are always reported together.
    a_done_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[18] == o_m_tdata[17])
        else $error("done and brake disagree");

    // A taken tick holds off the next one.
    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("second tick taken while one is in flight");

endmodule

// ----- sv/mtp_isqrt.sv -----
// Iterative floor square root, two radicand bits per cycle (restoring method).
// Depends on mtp_pkg for the radicand and root widths.
module mtp_isqrt
    import mtp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [MTP_RAD_W-1:0]  i_radicand,
    output logic                  o_done,
    output logic [MTP_ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(MTP_ROOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MTP_ROOT_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [MTP_RAD_W-1:0]  r_rad;
    logic [MTP_ROOT_W+1:0] r_rem;
    logic [MTP_ROOT_W-1:0] r_root;

    logic [MTP_ROOT_W+3:0] w_rem_sh;
    logic [MTP_ROOT_W+3:0] w_trial;
    logic [MTP_ROOT_W+3:0] w_diff;
    logic                  w_fits;

    // One step: bring down the next two radicand bits and try a one digit.
    assign w_rem_sh = {r_rem, r_rad[MTP_RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_fits   = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[MTP_RAD_W-3:0], 2'b00};
                if (w_fits) begin
                    r_rem  <= w_diff[MTP_ROOT_W+1:0];
                    r_root <= {r_root[MTP_ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh[MTP_ROOT_W+1:0];
                    r_root <= {r_root[MTP_ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    // A new root is never started over one still in progress.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root started while busy");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("square root done held high");

    // Completion only follows the last step of a run.
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy && $past(r_busy))
        else $error("square root done without a run");

endmodule

// ----- dv/move_to_position_velocity_profile_core_tb.sv -----
// Self-checking testbench for move_to_position_velocity_profile_core.
// Drives control ticks and register writes, predicts each result beat and compares it.
// Depends on mtp_pkg and the core RTL only.
module move_to_position_velocity_profile_core_tb;
    import mtp_pkg::*;

    localparam int N_CH        = MTP_CHANNELS;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_TICKS  = 80;
    localparam int SETTLE      = 40;

    // One control tick, packed so that it maps onto i_s_tdata from bit 0 upwards.
    typedef struct packed {
        logic        mode_entered;
        logic [31:0] speed_limit;
        logic [31:0] current_position;
        logic [31:0] goal_position;
        logic [1:0]  channel;
    } tick_t;

    // One result beat, packed as o_m_tdata.
    typedef struct packed {
        logic [2:0]  pad;
        logic        reset_controller;
        logic        clear_integral;
        logic        done_res;
        logic        brake;
        logic [16:0] velocity_setpoint;
    } setpoint_t;

    // Directed row: the tick, and a hand-written result where one is obvious.
    typedef struct packed {
        logic [1:0]  ch;
        logic [31:0] goal;
        logic [31:0] cur;
        logic [31:0] lim;
        logic        ent;
        logic        typed;
        logic [16:0] vel;
        logic        brake;
        logic        done;
        logic        clr;
        logic        rst;
    } dir_row_t;

    localparam int N_DIR = 17;
    localparam dir_row_t DIRECTED [N_DIR] = '{
        // Straight after reset the goal matches the cleared store: within deadband.
        '{2'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 17'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        // Done is sticky even though the error is now large.
        '{2'd0, 32'd0, 32'd5000, 32'd0, 1'b0, 1'b1, 17'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        // Mode entry clears done; speed-up towards the negative direction.
        '{2'd0, 32'd0, 32'd5000, 32'd0, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd0, 32'd0, 32'd5000, 32'd0, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        // Close in: the curve falls below the profile, so it slows down directly.
        '{2'd0, 32'd0, 32'd200, 32'd0, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd0, 32'd0, 32'd41, 32'd0, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        // Error exactly at the threshold counts as done.
        '{2'd0, 32'd0, 32'd40, 32'd0, 1'b0, 1'b1, 17'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        // Extreme positions: the difference wraps to -1, new goal resets the loop.
        '{2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, 1'b1,
          17'd0, 1'b1, 1'b1, 1'b0, 1'b1},
        // Error of -2^31: the curve product wraps to zero, minimum velocity applies.
        '{2'd2, 32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        // Limit below the minimum velocity wins.
        '{2'd3, 32'd100000, 32'd0, 32'd1, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd3, 32'd100000, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0,
          17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        // Negative limits select the default speed.
        '{2'd3, 32'd100000, 32'd0, 32'h8000_0000, 1'b0, 1'b0,
          17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd3, 32'd100000, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0,
          17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd1, -32'sd100000, 32'd0, 32'd0, 1'b1, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd1, -32'sd100000, 32'd0, 32'd0, 1'b0, 1'b0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{2'd1, -32'sd100000, -32'sd99995, 32'd0, 1'b0, 1'b1,
          17'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        // Mode entry inside the deadband: reset request and done again.
        '{2'd1, -32'sd100000, -32'sd99995, 32'd0, 1'b1, 1'b1,
          17'd0, 1'b1, 1'b1, 1'b0, 1'b1}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         o_s_tready;
    logic [103:0] s_tdata;
    logic         o_m_tvalid;
    logic         m_tready;
    logic [23:0]  o_m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    move_to_position_velocity_profile_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predicted channel state and register copy.
    logic [31:0] goal_held [N_CH];
    int          vel_held  [N_CH];
    logic        done_held [N_CH];
    logic [15:0] thr_set;
    logic [15:0] minv_set;
    logic [15:0] accel_set;
    logic [7:0]  decel_set;
    logic [15:0] defspd_set;

    setpoint_t setpoints_due [$];
    int        fail_count    = 0;
    int        ticks_sent    = 0;
    int        results_seen  = 0;
    int        settings_used = 0;
    int        burst_left    = 0;
    logic      hold_req      = 1'b0;
    int        holds_done    = 0;

    // Clock: period of 4 time units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Works out the result of one tick and advances the predicted channel state.
    function automatic setpoint_t next_setpoint(input tick_t t);
        setpoint_t   res;
        logic [1:0]  ch;
        logic [31:0] err;
        logic [31:0] mag;
        logic [31:0] lim;
        logic [31:0] prod;
        logic [31:0] root;
        logic [31:0] trial;
        logic [31:0] dmag;
        int          desired;
        int          acur;
        int          diff;
        int          stp;
        res = '0;
        ch  = t.channel;
        if (t.mode_entered) begin
            vel_held[ch]  = 0;
            done_held[ch] = 1'b0;
            res.reset_controller = 1'b1;
        end
        if (t.goal_position != goal_held[ch]) begin
            goal_held[ch] = t.goal_position;
            vel_held[ch]  = 0;
            done_held[ch] = 1'b0;
            res.reset_controller = 1'b1;
        end
        if (done_held[ch]) begin
            res.brake    = 1'b1;
            res.done_res = 1'b1;
            return res;
        end
        err = t.goal_position - t.current_position;
        mag = err[31] ? -err : err;
        if (t.speed_limit == 32'd0 || t.speed_limit[31])
            lim = {16'd0, defspd_set};
        else
            lim = t.speed_limit;
        if (mag <= {16'd0, thr_set}) begin
            vel_held[ch]  = 0;
            done_held[ch] = 1'b1;
            res.brake     = 1'b1;
            res.done_res  = 1'b1;
            return res;
        end
        // Deceleration curve: floor square root of a product that wraps at 32 bits.
        prod = 32'd2 * {24'd0, decel_set} * mag;
        root = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= prod)
                root = trial;
        end
        if (root < {16'd0, minv_set})
            root = {16'd0, minv_set};
        dmag    = (root < lim) ? root : lim;
        desired = err[31] ? -int'(dmag) : int'(dmag);
        acur    = (vel_held[ch] < 0) ? -vel_held[ch] : vel_held[ch];
        if (int'(dmag) >= acur) begin
            // Speeding up: bounded change per tick.
            stp  = int'(accel_set);
            diff = desired - vel_held[ch];
            if (diff > stp)
                diff = stp;
            else if (diff < -stp)
                diff = -stp;
            vel_held[ch] = vel_held[ch] + diff;
        end else begin
            vel_held[ch] = desired;
            res.clear_integral = 1'b1;
        end
        res.velocity_setpoint = vel_held[ch][16:0];
        return res;
    endfunction

    // Offers one tick, records its expected result on acceptance, then maybe pauses.
    task automatic send_tick(input tick_t t, input logic typed, input setpoint_t want);
        setpoint_t predicted;
        int        gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, t};
        do @(posedge i_clk); while (!o_s_tready);
        predicted = next_setpoint(t);
        setpoints_due.push_back(typed ? want : predicted);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 25);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 12);
        end
    endtask

    // Writes one register, reads it back, and updates the predicted copy.
    task automatic write_setting(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DONE_THR:  thr_set    = val[15:0];
            REG_MIN_VEL:   minv_set   = val[15:0];
            REG_ACC_STEP:  accel_set  = val[15:0];
            REG_DEC_FACT:  decel_set  = val[7:0];
            REG_DEF_SPEED: defspd_set = val[15:0];
            default: ;
        endcase
        // Read-back access follows directly.
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != val) begin
            $error("register %0d read-back: expected %0h, actual %0h", idx, val, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: tready patterns of varying length, plus one long hold on request.
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_tready <= 1'b0;
                end
                hold_req = 1'b0;
                holds_done++;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(8, 64);
            for (int i = 0; i < len; i++) begin
                @(negedge i_clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= (i % 4 != 3);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker: every beat against the oldest expectation.
    always @(posedge i_clk) begin
        setpoint_t got;
        setpoint_t exp_sp;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            got = o_m_tdata;
            results_seen++;
            if (setpoints_due.size() == 0) begin
                $error("result beat %0h with no tick outstanding", got);
                fail_count++;
            end else begin
                exp_sp = setpoints_due.pop_front();
                if (got.velocity_setpoint != exp_sp.velocity_setpoint) begin
                    $error("velocity_setpoint: expected %0d, actual %0d",
                           $signed(exp_sp.velocity_setpoint),
                           $signed(got.velocity_setpoint));
                    fail_count++;
                end
                if (got.brake != exp_sp.brake) begin
                    $error("brake: expected %0b, actual %0b", exp_sp.brake, got.brake);
                    fail_count++;
                end
                if (got.done_res != exp_sp.done_res) begin
                    $error("done_res: expected %0b, actual %0b",
                           exp_sp.done_res, got.done_res);
                    fail_count++;
                end
                if (got.clear_integral != exp_sp.clear_integral) begin
                    $error("clear_integral: expected %0b, actual %0b",
                           exp_sp.clear_integral, got.clear_integral);
                    fail_count++;
                end
                if (got.reset_controller != exp_sp.reset_controller) begin
                    $error("reset_controller: expected %0b, actual %0b",
                           exp_sp.reset_controller, got.reset_controller);
                    fail_count++;
                end
                if (got.pad != exp_sp.pad) begin
                    $error("padding: expected %0h, actual %0h", exp_sp.pad, got.pad);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any accepted beat or access.
    always @(posedge i_clk) begin
        int idle_cycles;
        if (!i_rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)
                || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** move_to_position_velocity_profile_core: FAILED **");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed rows, then random ticks under several settings.
    initial begin
        tick_t       t;
        setpoint_t   want;
        logic [31:0] pos_model  [N_CH];
        logic [31:0] goal_model [N_CH];
        logic [31:0] vals       [5];
        logic [2:0]  reg_code   [5];
        logic [31:0] gap32;
        logic [31:0] far;
        logic [31:0] off;
        int          stp;
        int          ch;

        reg_code = '{REG_DONE_THR, REG_MIN_VEL, REG_ACC_STEP, REG_DEC_FACT, REG_DEF_SPEED};
        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        thr_set    = RST_DONE_THR;
        minv_set   = RST_MIN_VEL;
        accel_set  = RST_ACC_STEP;
        decel_set  = RST_DEC_FACT;
        defspd_set = RST_DEF_SPEED;
        for (int i = 0; i < N_CH; i++) begin
            goal_held[i]  = '0;
            vel_held[i]   = 0;
            done_held[i]  = 1'b0;
            pos_model[i]  = '0;
            goal_model[i] = '0;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset register values.
        for (int r = 0; r < N_DIR; r++) begin
            t.channel          = DIRECTED[r].ch;
            t.goal_position    = DIRECTED[r].goal;
            t.current_position = DIRECTED[r].cur;
            t.speed_limit      = DIRECTED[r].lim;
            t.mode_entered     = DIRECTED[r].ent;
            want = '{3'd0, DIRECTED[r].rst, DIRECTED[r].clr, DIRECTED[r].done,
                     DIRECTED[r].brake, DIRECTED[r].vel};
            send_tick(t, DIRECTED[r].typed, want);
        end

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                // Let the core drain before touching its registers.
                @(negedge i_clk);
                s_tvalid <= 1'b0;
                while (setpoints_due.size() != 0) @(posedge i_clk);
                repeat (SETTLE) @(posedge i_clk);
                case (phase)
                    1: vals = '{32'd65535, 32'd65535, 32'd65535, 32'd255, 32'd65535};
                    2: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
                    3: vals = '{$urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 255),
                                $urandom_range(0, 65535)};
                    4: vals = '{32'd0, 32'd0, 32'd1, 32'd255, 32'd65535};
                    default: vals = '{RST_DONE_THR, RST_MIN_VEL, RST_ACC_STEP,
                                      RST_DEC_FACT, RST_DEF_SPEED};
                endcase
                for (int r = 0; r < 5; r++)
                    write_setting(reg_code[r], vals[r]);
                // Output held off for a long stretch while ticks keep coming.
                if (phase == 3)
                    hold_req = 1'b1;
            end
            settings_used++;

            for (int n = 0; n < RAND_TICKS; n++) begin
                ch = $urandom_range(0, N_CH - 1);
                // Occasionally a new goal, near or far from the current position.
                if ($urandom_range(0, 11) == 0) begin
                    case ($urandom_range(0, 3))
                        0: off = $urandom_range(0, 100);
                        1: off = $urandom_range(0, 5000);
                        2: off = $urandom_range(0, 500000);
                        default: off = '0;
                    endcase
                    if (off == '0)
                        goal_model[ch] = $urandom;
                    else
                        goal_model[ch] = $urandom_range(0, 1) ? pos_model[ch] + off
                                                              : pos_model[ch] - off;
                end
                // The motor moves towards its goal, sometimes overshooting it.
                gap32 = goal_model[ch] - pos_model[ch];
                far   = gap32[31] ? -gap32 : gap32;
                stp   = $urandom_range(0, 3000);
                if (far <= stp && $urandom_range(0, 7) != 0)
                    pos_model[ch] = goal_model[ch];
                else
                    pos_model[ch] = gap32[31] ? pos_model[ch] - stp : pos_model[ch] + stp;

                t.channel          = 2'(ch);
                t.goal_position    = goal_model[ch];
                t.current_position = ($urandom_range(0, 11) == 0) ? $urandom : pos_model[ch];
                case ($urandom_range(0, 7))
                    0: t.speed_limit = '0;
                    1: t.speed_limit = $urandom | 32'h8000_0000;
                    2: t.speed_limit = $urandom;
                    default: t.speed_limit = $urandom_range(1, 2500);
                endcase
                t.mode_entered = ($urandom_range(0, 19) == 0);
                send_tick(t, 1'b0, '0);
            end
        end

        // Drain and allow a little extra time for any stray beat.
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (setpoints_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d ticks (%0d directed) under %0d register settings.",
                 ticks_sent, N_DIR, settings_used);
        $display("%0d result beats checked; %0d long output hold(s) applied.",
                 results_seen, holds_done);
        if (fail_count == 0)
            $display("** move_to_position_velocity_profile_core: PASSED **");
        else
            $display("** move_to_position_velocity_profile_core: FAILED **");
        $finish;
    end

endmodule
